@@ hdl/bc1_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_pkg
// Types and constants shared by the block decoder modules.
// ----------------------------------------------------------------------------
package bc1_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_COLOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_MODE  = 1'd1;

  localparam int Q_DEPTH = 2;
  localparam int PAL_DEPTH = 256;

  localparam logic [7:0] PAL_MARK   = 8'h55;
  localparam logic [7:0] ALPHA_MARK = 8'hFF;
  localparam logic [7:0] OPAQUE     = 8'hFF;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] pixel_row;
    logic [1:0] pixel_col;
    logic       last_pixel;
  } out_t;

  typedef struct packed {
    logic ext_en;
    logic pal_en;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pix_t;

  typedef struct packed {
    pix_t [3:0]  clr;
    logic [31:0] idx;
  } q_entry_t;

endpackage

@@ hdl/bc1_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_front
// Accepts items, keeps the palette, selects endpoints and builds the four
// block colours, then pushes one entry per decoded block into the queue.
// ----------------------------------------------------------------------------
module bc1_front
  import bc1_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_t      in_data,
  input  cfg_t     cfg,
  output logic     q_push,
  output q_entry_t q_data,
  input  logic     q_full
);

  localparam int PAL_AW = $clog2(PAL_DEPTH);

  logic [23:0] pal_mem [PAL_DEPTH];

  logic        s1_v_r;
  logic [63:0] s1_lo_r;
  logic [63:0] s1_hi_r;
  logic [23:0] p0_r;
  logic [23:0] p1_r;

  logic        s2_v_r;
  logic [23:0] s2_c0_r;
  logic [23:0] s2_c1_r;
  logic        s2_solid_r;
  logic        s2_clear_r;
  logic        s2_four_r;
  logic [31:0] s2_idx_r;

  logic        accept;
  logic        acc_dec;
  logic        acc_wr;
  logic        s1_go;
  logic        s2_go;
  logic        s2_load;
  logic        s1_v_nxt;
  logic        s2_v_nxt;

  logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
  logic [15:0] w0, w1;
  logic        pal, ext, solid;
  logic [23:0] c0_nxt, c1_nxt;

  function automatic logic [23:0] ep565(input logic [7:0] lo, input logic [7:0] hi);
    ep565 = {hi[7:3], hi[7:5], hi[2:0], lo[7:5], hi[2:1], lo[4:0], lo[4:2]};
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] x, input logic [7:0] y);
    logic [11:0] s;
    s = 12'(x) * 12'd11 + 12'(y) * 12'd5;
    blend = s[11:4];
  endfunction

  function automatic logic [7:0] avg(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = 9'(x) + 9'(y);
    avg = s[8:1];
  endfunction

  // handshake and stage flow
  assign s2_go    = s2_v_r && !q_full;
  assign s2_load  = s1_v_r && (!s2_v_r || s2_go);
  assign s1_go    = s2_load;
  assign in_stall = s1_v_r && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign acc_dec  = accept && !in_data.operation;
  assign acc_wr   = accept && in_data.operation;

  assign s1_v_nxt = acc_dec ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
  assign s2_v_nxt = s2_load ? 1'b1 : (s2_go ? 1'b0 : s2_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // palette store and endpoint reads
  always_ff @(posedge clk) begin
    if (acc_wr) begin
      pal_mem[in_data.palette_index[PAL_AW-1:0]] <= in_data.palette_color;
    end
    if (acc_dec) begin
      p0_r    <= pal_mem[in_data.block_low[8+PAL_AW-1:8]];
      p1_r    <= pal_mem[in_data.block_low[24+PAL_AW-1:24]];
      s1_lo_r <= in_data.block_low;
      s1_hi_r <= in_data.block_high;
    end
  end

  // classification and endpoint selection
  always_comb begin
    {b7, b6, b5, b4, b3, b2, b1, b0} = s1_lo_r;
    w0    = {b1, b0};
    w1    = {b3, b2};
    pal   = cfg.pal_en && (b0 == PAL_MARK) && (b2 == PAL_MARK);
    ext   = !pal && cfg.ext_en && (s1_hi_r != 64'd0);
    solid = (w0 == w1) && (b4 == b5) && (b5 == b6) && (b6 == b7);
    if (pal) begin
      c0_nxt = p0_r;
      c1_nxt = p1_r;
    end else if (ext) begin
      c0_nxt = {s1_hi_r[7:0], s1_hi_r[15:8], s1_hi_r[23:16]};
      c1_nxt = {s1_hi_r[39:32], s1_hi_r[47:40], s1_hi_r[55:48]};
    end else begin
      c0_nxt = ep565(b0, b1);
      c1_nxt = ep565(b2, b3);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_c0_r    <= c0_nxt;
      s2_c1_r    <= c1_nxt;
      s2_solid_r <= solid;
      s2_clear_r <= (b4 == ALPHA_MARK);
      s2_four_r  <= (w0 > w1);
      s2_idx_r   <= s1_lo_r[63:32];
    end
  end

  // colour table
  always_comb begin
    q_data.idx = s2_idx_r;
    if (s2_solid_r) begin
      q_data.clr = {4{s2_c0_r, s2_clear_r ? 8'h00 : OPAQUE}};
    end else begin
      q_data.clr[0] = {s2_c0_r, OPAQUE};
      q_data.clr[1] = {s2_c1_r, OPAQUE};
      if (s2_four_r) begin
        q_data.clr[2] = {blend(s2_c0_r[23:16], s2_c1_r[23:16]),
                         blend(s2_c0_r[15:8], s2_c1_r[15:8]),
                         blend(s2_c0_r[7:0], s2_c1_r[7:0]), OPAQUE};
        q_data.clr[3] = {blend(s2_c1_r[23:16], s2_c0_r[23:16]),
                         blend(s2_c1_r[15:8], s2_c0_r[15:8]),
                         blend(s2_c1_r[7:0], s2_c0_r[7:0]), OPAQUE};
      end else begin
        q_data.clr[2] = {avg(s2_c0_r[23:16], s2_c1_r[23:16]),
                         avg(s2_c0_r[15:8], s2_c1_r[15:8]),
                         avg(s2_c0_r[7:0], s2_c1_r[7:0]), OPAQUE};
        q_data.clr[3] = {q_data.clr[2].r, q_data.clr[2].g, q_data.clr[2].b, 8'h00};
      end
    end
  end

  assign q_push = s2_go;

endmodule

@@ hdl/bc1_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_queue
// Short queue of decoded block entries between front and back.
// ----------------------------------------------------------------------------
module bc1_queue
  import bc1_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output q_entry_t head
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  q_entry_t        mem_r [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full  = (count_r == CW'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/bc1_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_back
// Walks the sixteen pixels of the head block, applies 2x2 smoothing to
// pixels outside the last row and column and drives the result register.
// ----------------------------------------------------------------------------
module bc1_back
  import bc1_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  q_entry_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r;
  out_t       pix_nxt;
  logic       emit;
  logic [1:0] row, col, row1, col1;
  pix_t       p00, p01, p10, p11;
  logic       smooth;

  function automatic logic [1:0] sel(input logic [31:0] idx, input logic [1:0] r,
                                     input logic [1:0] c);
    sel = idx[{r, c, 1'b0} +: 2];
  endfunction

  function automatic logic [7:0] filt(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    logic [13:0] s;
    s = 14'(a) * 14'd26 + 14'(b) * 14'd14 + 14'(c) * 14'd14 + 14'(d) * 14'd10;
    filt = s[13:6];
  endfunction

  assign emit  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop = emit && (cnt_r == 4'd15);

  always_comb begin
    row    = cnt_r[3:2];
    col    = cnt_r[1:0];
    row1   = row + 2'd1;
    col1   = col + 2'd1;
    smooth = (row != 2'd3) && (col != 2'd3);
    p00    = q_head.clr[sel(q_head.idx, row, col)];
    p01    = q_head.clr[sel(q_head.idx, row, col1)];
    p10    = q_head.clr[sel(q_head.idx, row1, col)];
    p11    = q_head.clr[sel(q_head.idx, row1, col1)];
    if (smooth) begin
      pix_nxt.red   = filt(p00.r, p01.r, p10.r, p11.r);
      pix_nxt.green = filt(p00.g, p01.g, p10.g, p11.g);
      pix_nxt.blue  = filt(p00.b, p01.b, p10.b, p11.b);
      pix_nxt.alpha = filt(p00.a, p01.a, p10.a, p11.a);
    end else begin
      pix_nxt.red   = p00.r;
      pix_nxt.green = p00.g;
      pix_nxt.blue  = p00.b;
      pix_nxt.alpha = p00.a;
    end
    pix_nxt.pixel_row  = row;
    pix_nxt.pixel_col  = col;
    pix_nxt.last_pixel = (cnt_r == 4'd15);
  end

  assign cnt_nxt       = emit ? cnt_r + 4'd1 : cnt_r;
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/bc1_block_decode_with_extensions_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_block_decode_with_extensions_top
// 4x4 colour block decoder with 8-bit endpoint override, palette endpoints
// and 2x2 smoothing; sixteen RGBA pixels per decoded block.
// ----------------------------------------------------------------------------
// path: stage 1, stage 2 and queue registers, then the output register
// throughput: one pixel per cycle while the queue holds a block and the
//   output is not stalled, set by the pixel walk of the back end; a palette write gives no result
// reset: synchronous active low, clears control state and both config
//   registers; palette contents are undefined until written
// ----------------------------------------------------------------------------
module bc1_block_decode_with_extensions_top
  import bc1_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  cfg_t     cfg_r;
  q_entry_t q_data;
  q_entry_t q_head;
  logic     q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXT_COLOR: cfg_r.ext_en <= cfg_wdata;
        REG_PAL_MODE:  cfg_r.pal_en <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bc1_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_push   (q_push),
    .q_data   (q_data),
    .q_full   (q_full)
  );

  bc1_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  bc1_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/bc1_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_chk
// Port-level checks on the pixel output stream of the block decoder.
// ----------------------------------------------------------------------------
module bc1_chk
  import bc1_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // stalled pixel is held
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled pixel changed");

  // last flag marks the bottom right pixel only
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_pixel ==
                  (out_data.pixel_row == 2'd3 && out_data.pixel_col == 2'd3))
    else $error("last pixel flag misplaced");

  // pixels of a block come in row order
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_pixel) ##1 out_valid |->
      {out_data.pixel_row, out_data.pixel_col} ==
      4'($past({out_data.pixel_row, out_data.pixel_col}, 1) + 4'd1))
    else $error("pixel order broken");

  // no result straight out of reset
  assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind bc1_block_decode_with_extensions_top bc1_chk u_chk (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the BC1 block decoder with override and palette
// endpoints. A scoreboard predicts the sixteen smoothed pixels of every
// decoded block and tracks palette writes. Each pixel transfer is checked in
// order against the prediction. Directed blocks cover solid, four-colour,
// three-colour, override and palette cases. Random traffic then runs under
// every register setting, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import bc1_pkg::*;

  localparam logic OP_DECODE    = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 84;

  class bc1_pixel_board;
    logic [23:0] palette [PAL_DEPTH];
    logic ext_en;
    logic pal_en;
    out_t expected_px [$];
    int unsigned mismatches;
    int unsigned n_blocks, n_pal_writes, n_pixels;
    int unsigned n_solid, n_four, n_three, n_pal, n_ext;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
      case (idx)
        REG_EXT_COLOR: ext_en = val;
        REG_PAL_MODE:  pal_en = val;
        default: ;
      endcase
    endfunction

    function pix_t unpack565(logic [7:0] lo, logic [7:0] hi);
      logic [7:0] r, g, b;
      pix_t p;
      r = hi & 8'hF8;
      g = {hi[2:0], lo[7:5], 2'b00};
      b = {lo[4:0], 3'b000};
      p.r = r | (r >> 5);
      p.g = g | (g >> 6);
      p.b = b | (b >> 5);
      p.a = OPAQUE;
      return p;
    endfunction

    function pix_t blend(pix_t x, pix_t y, int unsigned wx, int unsigned wy, int unsigned sh);
      pix_t p;
      p.r = 8'((wx * x.r + wy * y.r) >> sh);
      p.g = 8'((wx * x.g + wy * y.g) >> sh);
      p.b = 8'((wx * x.b + wy * y.b) >> sh);
      p.a = OPAQUE;
      return p;
    endfunction

    function logic [7:0] weigh(logic [7:0] p00, logic [7:0] p01, logic [7:0] p10,
                               logic [7:0] p11);
      return 8'((26 * p00 + 14 * p01 + 14 * p10 + 10 * p11) >> 6);
    endfunction

    function void note_item(in_t it);
      logic [7:0] blk [16];
      logic [15:0] w0, w1;
      logic pal, ext, solid;
      pix_t clr [4];
      pix_t px [16];
      pix_t v;
      out_t o;
      logic [7:0] fill_a;
      int r, c, i;
      if (it.operation == OP_PAL_WRITE) begin
        palette[it.palette_index] = it.palette_color;
        n_pal_writes++;
        return;
      end
      n_blocks++;
      for (i = 0; i < 8; i++) begin
        blk[i]     = it.block_low[8*i +: 8];
        blk[8 + i] = it.block_high[8*i +: 8];
      end
      w0 = {blk[1], blk[0]};
      w1 = {blk[3], blk[2]};
      pal = pal_en && blk[0] == PAL_MARK && blk[2] == PAL_MARK;
      ext = !pal && ext_en && (it.block_high != '0);
      solid = (w0 == w1) && blk[4] == blk[5] && blk[5] == blk[6] && blk[6] == blk[7];
      if (pal) begin
        n_pal++;
        clr[0] = {palette[blk[1]], OPAQUE};
        clr[1] = {palette[blk[3]], OPAQUE};
      end else if (ext) begin
        n_ext++;
        clr[0] = {blk[8], blk[9], blk[10], OPAQUE};
        clr[1] = {blk[12], blk[13], blk[14], OPAQUE};
      end else begin
        clr[0] = unpack565(blk[0], blk[1]);
        clr[1] = unpack565(blk[2], blk[3]);
      end
      if (solid) begin
        n_solid++;
        fill_a = (blk[4] == ALPHA_MARK) ? 8'h00 : 8'hFF;
        for (i = 0; i < 16; i++) px[i] = {clr[0].r, clr[0].g, clr[0].b, fill_a};
      end else begin
        if (w0 > w1) begin
          n_four++;
          clr[2] = blend(clr[0], clr[1], 11, 5, 4);
          clr[3] = blend(clr[0], clr[1], 5, 11, 4);
        end else begin
          n_three++;
          clr[2] = blend(clr[0], clr[1], 1, 1, 1);
          clr[3] = clr[2];
          clr[3].a = 8'h00;
        end
        for (r = 0; r < 4; r++)
          for (c = 0; c < 4; c++) px[r*4 + c] = clr[blk[4 + r][2*c +: 2]];
      end
      for (i = 0; i < 16; i++) begin
        r = i / 4;
        c = i % 4;
        v = px[i];
        if (r < 3 && c < 3) begin
          v.r = weigh(px[i].r, px[i+1].r, px[i+4].r, px[i+5].r);
          v.g = weigh(px[i].g, px[i+1].g, px[i+4].g, px[i+5].g);
          v.b = weigh(px[i].b, px[i+1].b, px[i+4].b, px[i+5].b);
          v.a = weigh(px[i].a, px[i+1].a, px[i+4].a, px[i+5].a);
        end
        o.red        = v.r;
        o.green      = v.g;
        o.blue       = v.b;
        o.alpha      = v.a;
        o.pixel_row  = 2'(r);
        o.pixel_col  = 2'(c);
        o.last_pixel = (i == 15);
        expected_px.push_back(o);
      end
    endfunction

    function void check_pixel(out_t got);
      out_t want;
      n_pixels++;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel transfer with nothing pending: rgba %h %h %h %h row %0d col %0d",
                   got.red, got.green, got.blue, got.alpha, got.pixel_row, got.pixel_col);
        return;
      end
      want = expected_px.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.pixel_row !== want.pixel_row ||
          got.pixel_col !== want.pixel_col || got.last_pixel !== want.last_pixel) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %0t: exp %h %h %h %h r%0d c%0d l%0b got %h %h %h %h r%0d c%0d l%0b",
                   $realtime, want.red, want.green, want.blue, want.alpha,
                   want.pixel_row, want.pixel_col, want.last_pixel,
                   got.red, got.green, got.blue, got.alpha,
                   got.pixel_row, got.pixel_col, got.last_pixel);
      end
    endfunction

    function void close_out();
      if (expected_px.size() != 0) begin
        mismatches++;
        $display("%0d expected pixels never arrived", expected_px.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic cfg_wdata;

  bc1_pixel_board decode_board = new;
  bit calm = 1'b0;
  logic [7:0] written_idx [$];
  bit pal_written [PAL_DEPTH];
  int unsigned idle_cycles = 0;

  bc1_block_decode_with_extensions_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall = !calm && ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) decode_board.check_pixel(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("bc1_block_decode_with_extensions_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_t block_item(logic [63:0] lo, logic [63:0] hi);
    in_t it;
    it.operation     = OP_DECODE;
    it.block_low     = lo;
    it.block_high    = hi;
    it.palette_index = 8'($urandom);
    it.palette_color = 24'($urandom);
    return it;
  endfunction

  function automatic in_t pal_item(logic [7:0] idx, logic [23:0] colour);
    in_t it;
    it.operation     = OP_PAL_WRITE;
    it.block_low     = {$urandom, $urandom};
    it.block_high    = {$urandom, $urandom};
    it.palette_index = idx;
    it.palette_color = colour;
    if (!pal_written[idx]) begin
      pal_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
    return it;
  endfunction

  function automatic logic [7:0] pick_written();
    return written_idx[$urandom_range(0, written_idx.size() - 1)];
  endfunction

  function automatic in_t random_item();
    in_t it;
    int kind;
    if ($urandom_range(0, 4) == 0) return pal_item(8'($urandom), 24'($urandom));
    it = block_item({$urandom, $urandom}, {$urandom, $urandom});
    kind = $urandom_range(0, 9);
    case (kind)
      0: it.block_high = '0;
      1: begin
        it.block_low[31:16] = it.block_low[15:0];
        it.block_low[63:32] = $urandom_range(0, 1) ? '1 : {4{it.block_low[39:32]}};
      end
      2: it.block_low[31:16] = it.block_low[15:0];
      3: it.block_high = 64'(8'($urandom)) << (8 * $urandom_range(0, 7));
      4, 5: begin
        it.block_low[7:0]   = PAL_MARK;
        it.block_low[23:16] = PAL_MARK;
      end
      default: ;
    endcase
    if (it.block_low[7:0] == PAL_MARK && it.block_low[23:16] == PAL_MARK) begin
      it.block_low[15:8]  = pick_written();
      it.block_low[31:24] = pick_written();
      if (kind == 5) begin
        it.block_low[31:24] = it.block_low[15:8];
        it.block_low[63:32] = $urandom_range(0, 1) ? '1 : {4{it.block_low[39:32]}};
      end
    end
    return it;
  endfunction

  task automatic push_item(input in_t it);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_board.note_item(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait until every predicted pixel has been transferred, then let the pipe empty
  task automatic settle();
    in_valid = 1'b0;
    while (decode_board.expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    decode_board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_config(input logic ext, input logic pal);
    settle();
    write_reg(REG_EXT_COLOR, ext);
    write_reg(REG_PAL_MODE, pal);
  endtask

  task automatic run_directed();
    push_item(pal_item(8'h00, 24'h000000));
    push_item(pal_item(8'hFF, 24'hFFFFFF));
    push_item(pal_item(8'h55, 24'h80C040));
    push_item(pal_item(8'hAA, 24'h123456));
    // plain 565 endpoints
    push_item(block_item(64'h0, 64'h0));
    push_item(block_item('1, '1));
    push_item(block_item(64'h1B1B_E4E4_0000_FFFF, 64'h0));
    push_item(block_item(64'hFFE4_1BFF_FFFF_0000, 64'h0));
    push_item(block_item(64'h0000_00FF_1234_1234, 64'h8000_0000_0000_0001));
    push_item(block_item(64'hAA55_AA55_FF55_0055, 64'h0));
    // 8-bit override, and 565 fallback for a zero high word
    apply_config(1'b1, 1'b0);
    push_item(block_item(64'h4E4E_B1B1_0821_F81F, 64'h003C_2A10_00F0_80FF));
    push_item(block_item(64'h4E4E_B1B1_0821_F81F, 64'h0));
    push_item(block_item(64'h7777_7777_ABCD_ABCD, 64'h01FF_EEDD_00CC_BBAA));
    push_item(block_item(64'hFFFF_FFFF_ABCD_ABCD, 64'h0000_0000_0000_00FF));
    // palette endpoints, override ignored
    apply_config(1'b1, 1'b1);
    push_item(block_item(64'h1BE4_1BE4_0055_FF55, 64'h1122_3344_5566_7788));
    push_item(block_item(64'hFFFF_FFFF_AA55_AA55, 64'h1));
    push_item(block_item(64'h36C9_9C63_AA55_5555, '1));
    apply_config(1'b0, 1'b1);
    push_item(block_item(64'h0000_0000_5555_5555, 64'h0));
    push_item(block_item(64'hE41B_E41B_0055_AA55, 64'h0));
  endtask

  initial begin
    bit phase_ext [5];
    bit phase_pal [5];
    int ph, n;
    phase_ext = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_pal = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_EXT_COLOR;
    cfg_wdata = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_reg(REG_EXT_COLOR, 1'b0);
    write_reg(REG_PAL_MODE, 1'b0);
    run_directed();
    for (ph = 0; ph < 5; ph++) begin
      apply_config(phase_ext[ph], phase_pal[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        calm = (ph == 1 && n >= 20 && n < 70);
        if (ph == 2 && n == PHASE_ITEMS / 2) settle();
        push_item(random_item());
      end
    end
    calm = 1'b0;
    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    decode_board.close_out();
    $display("%0d blocks (%0d solid, %0d four-colour, %0d three-colour), %0d palette writes",
             decode_board.n_blocks, decode_board.n_solid, decode_board.n_four,
             decode_board.n_three, decode_board.n_pal_writes);
    $display("%0d palette-endpoint and %0d override blocks, %0d pixels checked, %0d mismatches",
             decode_board.n_pal, decode_board.n_ext, decode_board.n_pixels,
             decode_board.mismatches);
    if (decode_board.mismatches == 0) begin
      $display("bc1_block_decode_with_extensions_top verification clean");
    end else begin
      $display("bc1_block_decode_with_extensions_top verification failed");
    end
    $finish;
  end

endmodule
